[src/a64dp_pkg.sv]
package a64dp_pkg;

    localparam int XLEN       = 64;
    localparam int HALF_XLEN  = XLEN / 2;
    localparam int REG_COUNT  = 31;
    localparam int REG_ADDR_W = $clog2(REG_COUNT);

    localparam logic [REG_ADDR_W-1:0] ZERO_REG = 5'b11111;

    localparam logic [15:0] HALF_MASK = 16'hFFFF;
    localparam int unsigned HALF_SHIFT = 16;
    localparam int unsigned IMM_SHIFT  = 12;

    // result status codes
    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_UNDEF_GROUP    = 2'd1;
    localparam logic [1:0] ST_RESERVED       = 2'd2;
    localparam logic [1:0] ST_SP_UNSUPPORTED = 2'd3;

    // immediate group selector, bits [25:23]
    localparam logic [2:0] OPI_ADD_SUB   = 3'b010;
    localparam logic [2:0] OPI_MOVE_WIDE = 3'b101;

    // wide move opc
    localparam logic [1:0] MOV_N    = 2'b00;
    localparam logic [1:0] MOV_RSVD = 2'b01;
    localparam logic [1:0] MOV_Z    = 2'b10;
    localparam logic [1:0] MOV_K    = 2'b11;

    // logic opc
    localparam logic [1:0] LOG_AND  = 2'b00;
    localparam logic [1:0] LOG_ORR  = 2'b01;
    localparam logic [1:0] LOG_EOR  = 2'b10;
    localparam logic [1:0] LOG_ANDS = 2'b11;

    // shift types
    localparam logic [1:0] SHIFT_LSL = 2'b00;
    localparam logic [1:0] SHIFT_LSR = 2'b01;
    localparam logic [1:0] SHIFT_ASR = 2'b10;
    localparam logic [1:0] SHIFT_ROR = 2'b11;

    // NZCV bit positions
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef struct packed {
        logic [XLEN-1:0] res;
        logic [3:0]      nzcv;
    } t_addsub;

endpackage

[src/a64dp_in_if.sv]
interface a64dp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic        immediate_group;

    modport source (output valid, output instruction_word, output immediate_group,
                    input ready);
    modport sink   (input valid, input instruction_word, input immediate_group,
                    output ready);
endinterface

[src/a64dp_out_if.sv]
interface a64dp_out_if;
    logic                          valid;
    logic                          ready;
    logic [4:0]                    dest_index;
    logic                          write_enable;
    logic [a64dp_pkg::XLEN-1:0]    write_value;
    logic                          flag_n;
    logic                          flag_z;
    logic                          flag_c;
    logic                          flag_v;
    logic [1:0]                    status;

    modport source (output valid, output dest_index, output write_enable,
                    output write_value, output flag_n, output flag_z, output flag_c,
                    output flag_v, output status, input ready);
    modport sink   (input valid, input dest_index, input write_enable,
                    input write_value, input flag_n, input flag_z, input flag_c,
                    input flag_v, input status, output ready);
endinterface

[src/a64dp_ram.sv]
module a64dp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/a64_data_processing_execute_core.sv]
// Flow: an instruction transferred in is held in the execute register, then its
//   result is registered in the output register; MADD/MSUB first register partials.
// Throughput: one instruction per cycle without output stalls; MADD/MSUB stall input
//   for the 64-bit multiply (three 32x32 partial products, then the accumulate add).
// Reset: i_rst_n is synchronous and active low; it empties the pipeline, clears NZCV
//   and marks every general register as zero through per-register valid bits.
module a64_data_processing_execute_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    a64dp_in_if.sink     i_in,
    a64dp_out_if.source  o_out
);

    localparam int XLEN  = a64dp_pkg::XLEN;
    localparam int HXLEN = a64dp_pkg::HALF_XLEN;
    localparam int AW    = a64dp_pkg::REG_ADDR_W;
    localparam int NREG  = a64dp_pkg::REG_COUNT;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [XLEN-1:0] width_mask(input logic sf);
        width_mask = sf ? {XLEN{1'b1}} : {{HXLEN{1'b0}}, {HXLEN{1'b1}}};
    endfunction

    function automatic logic top_bit(input logic [XLEN-1:0] v, input logic sf);
        top_bit = sf ? v[XLEN-1] : v[HXLEN-1];
    endfunction

    // Second-operand shifter; rotate by zero falls out as the operand itself.
    function automatic logic [XLEN-1:0] shift_op(input logic [XLEN-1:0] v,
                                                 input logic [1:0] kind,
                                                 input logic [5:0] amt,
                                                 input logic sf);
        logic [XLEN-1:0]   m;
        logic [XLEN-1:0]   vm;
        logic [2*XLEN-1:0] rot_w;
        logic [XLEN-1:0]   rot_h;
        m     = width_mask(sf);
        vm    = v & m;
        rot_w = {vm, vm} >> amt;
        rot_h = {vm[HXLEN-1:0], vm[HXLEN-1:0]} >> amt;
        case (kind)
            a64dp_pkg::SHIFT_LSL: shift_op = (vm << amt) & m;
            a64dp_pkg::SHIFT_LSR: shift_op = vm >> amt;
            a64dp_pkg::SHIFT_ASR: shift_op = sf ? XLEN'($signed(vm) >>> amt)
                : {{HXLEN{1'b0}}, HXLEN'($signed(vm[HXLEN-1:0]) >>> amt)};
            default:              shift_op = sf ? rot_w[XLEN-1:0]
                : {{HXLEN{1'b0}}, rot_h[HXLEN-1:0]};
        endcase
    endfunction

    // Add or subtract with NZCV; subtract is a + ~b + 1.
    function automatic a64dp_pkg::t_addsub add_sub(input logic sub,
                                                   input logic [XLEN-1:0] a,
                                                   input logic [XLEN-1:0] b,
                                                   input logic sf);
        logic [XLEN-1:0] m;
        logic [XLEN-1:0] am;
        logic [XLEN-1:0] b2;
        logic [XLEN:0]   s;
        logic [XLEN-1:0] res;
        logic [XLEN-1:0] vx;
        m   = width_mask(sf);
        am  = a & m;
        b2  = sub ? (~b & m) : (b & m);
        s   = {1'b0, am} + {1'b0, b2} + {{XLEN{1'b0}}, sub};
        res = s[XLEN-1:0] & m;
        vx  = ~(am ^ b2) & (am ^ res);
        add_sub.res  = res;
        add_sub.nzcv = {top_bit(res, sf), (res == '0), (sf ? s[XLEN] : s[HXLEN]),
                        top_bit(vx, sf)};
    endfunction

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic          in_xfer;
    logic          out_xfer;
    logic          ex_done;
    logic          ex_fire;
    logic          is_mul;
    logic          reg_we;

    logic          r_ex_valid;
    logic [31:0]   r_iw;
    logic          r_imm;
    logic          r_mul_phase;
    logic          r_out_valid;

    logic [NREG-1:0] r_valid;
    logic [3:0]      r_flags;

    assign is_mul   = !r_imm && r_iw[28];
    assign ex_done  = r_ex_valid && (!is_mul || r_mul_phase);
    assign ex_fire  = ex_done && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_ex_valid || ex_fire;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_out_valid && o_out.ready;

    // ------------------------------------------------------------------
    // Register file: three copies, read at transfer-in, written at retire
    // ------------------------------------------------------------------
    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;
    logic [AW-1:0]   addr_c;
    logic [XLEN-1:0] ram_a;
    logic [XLEN-1:0] ram_b;
    logic [XLEN-1:0] ram_c;
    logic [AW-1:0]   ex_rd;
    logic [XLEN-1:0] ex_res;
    logic [1:0]      ex_status;
    logic [3:0]      ex_flags;

    assign addr_a = i_in.instruction_word[9:5];
    assign addr_b = i_in.instruction_word[20:16];
    // movk merges into rd; multiply accumulates ra
    assign addr_c = i_in.immediate_group ? i_in.instruction_word[4:0]
                                         : i_in.instruction_word[14:10];

    assign reg_we = ex_fire && (ex_status == a64dp_pkg::ST_OK) && (ex_rd != a64dp_pkg::ZERO_REG);

    a64dp_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_ram_a (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(ex_rd), .i_wdata(ex_res),
        .i_re(in_xfer), .i_raddr(addr_a), .o_rdata(ram_a)
    );
    a64dp_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_ram_b (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(ex_rd), .i_wdata(ex_res),
        .i_re(in_xfer), .i_raddr(addr_b), .o_rdata(ram_b)
    );
    a64dp_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_ram_c (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(ex_rd), .i_wdata(ex_res),
        .i_re(in_xfer), .i_raddr(addr_c), .o_rdata(ram_c)
    );

    // Bypass: a retire at the same edge as the read wins over the stale RAM data.
    logic            r_hit_a, r_hit_b, r_hit_c;
    logic            r_ok_a, r_ok_b, r_ok_c;
    logic [XLEN-1:0] r_fwd_val;
    logic [XLEN-1:0] op_a, op_b, op_c;

    assign op_a = r_hit_a ? r_fwd_val : (r_ok_a ? ram_a : '0);
    assign op_b = r_hit_b ? r_fwd_val : (r_ok_b ? ram_b : '0);
    assign op_c = r_hit_c ? r_fwd_val : (r_ok_c ? ram_c : '0);

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic [AW-1:0]   ex_rn;
    logic [1:0]      ex_opc;
    logic            ex_sf;
    logic [XLEN-1:0] ex_mask;
    logic [5:0]      ex_amt;
    logic [1:0]      ex_kind;

    assign ex_rd   = r_iw[4:0];
    assign ex_rn   = r_iw[9:5];
    assign ex_opc  = r_iw[30:29];
    assign ex_sf   = r_iw[31];
    assign ex_mask = width_mask(ex_sf);
    assign ex_amt  = r_iw[15:10];
    assign ex_kind = r_iw[23:22];

    // add/sub immediate
    logic [XLEN-1:0]      imm_op2;
    a64dp_pkg::t_addsub   as_imm;
    assign imm_op2 = XLEN'(r_iw[21:10]) << (r_iw[22] ? a64dp_pkg::IMM_SHIFT : 0);
    assign as_imm  = add_sub(ex_opc[1], op_a, imm_op2, ex_sf);

    // wide moves
    logic [1:0]      mw_hw;
    logic [5:0]      mw_sh;
    logic [XLEN-1:0] mw_op;
    logic [XLEN-1:0] mw_keep;
    assign mw_hw   = r_iw[22:21];
    assign mw_sh   = 6'(mw_hw * a64dp_pkg::HALF_SHIFT);
    assign mw_op   = XLEN'(r_iw[20:5]) << mw_sh;
    assign mw_keep = ~(XLEN'(a64dp_pkg::HALF_MASK) << mw_sh);

    // shifted register arithmetic and logic
    logic [XLEN-1:0]    sh_b;
    logic [XLEN-1:0]    log_b;
    logic [XLEN-1:0]    log_a;
    logic [XLEN-1:0]    log_res;
    a64dp_pkg::t_addsub as_reg;
    assign sh_b   = shift_op(op_b, ex_kind, ex_amt, ex_sf);
    assign as_reg = add_sub(ex_opc[1], op_a, sh_b, ex_sf);
    assign log_a  = op_a & ex_mask;
    assign log_b  = r_iw[21] ? (~sh_b & ex_mask) : sh_b;

    always_comb begin
        case (ex_opc)
            a64dp_pkg::LOG_ORR: log_res = log_a | log_b;
            a64dp_pkg::LOG_EOR: log_res = log_a ^ log_b;
            default:            log_res = log_a & log_b;
        endcase
    end

    // multiply: partial products are registered first, then accumulated
    logic [XLEN-1:0]  mul_ll;
    logic [HXLEN-1:0] mul_lh;
    logic [HXLEN-1:0] mul_hl;
    logic [XLEN-1:0]  r_p0;
    logic [HXLEN-1:0] r_p1;
    logic [HXLEN-1:0] r_p2;
    logic [XLEN-1:0]  r_acc;
    logic [XLEN-1:0]  mul_prod;
    logic [XLEN-1:0]  mul_res;

    assign mul_ll   = {{HXLEN{1'b0}}, op_a[HXLEN-1:0]} * {{HXLEN{1'b0}}, op_b[HXLEN-1:0]};
    assign mul_lh   = op_a[HXLEN-1:0] * op_b[XLEN-1:HXLEN];
    assign mul_hl   = op_a[XLEN-1:HXLEN] * op_b[HXLEN-1:0];
    assign mul_prod = r_p0 + {r_p1 + r_p2, {HXLEN{1'b0}}};
    assign mul_res  = (r_iw[15] ? (r_acc - mul_prod) : (r_acc + mul_prod)) & ex_mask;

    always_comb begin
        ex_status = a64dp_pkg::ST_OK;
        ex_res    = '0;
        ex_flags  = r_flags;
        if (r_imm) begin
            unique case (r_iw[25:23])
                a64dp_pkg::OPI_ADD_SUB: begin
                    // SP-relative forms are not supported
                    if (ex_rn == a64dp_pkg::ZERO_REG
                        || (ex_rd == a64dp_pkg::ZERO_REG && !ex_opc[0])) begin
                        ex_status = a64dp_pkg::ST_SP_UNSUPPORTED;
                    end else begin
                        ex_res = as_imm.res;
                        if (ex_opc[0]) begin
                            ex_flags = as_imm.nzcv;
                        end
                    end
                end
                a64dp_pkg::OPI_MOVE_WIDE: begin
                    if (ex_opc == a64dp_pkg::MOV_RSVD || (!ex_sf && mw_hw[1])) begin
                        ex_status = a64dp_pkg::ST_RESERVED;
                    end else begin
                        unique case (ex_opc)
                            a64dp_pkg::MOV_N: ex_res = ~mw_op & ex_mask;
                            a64dp_pkg::MOV_Z: ex_res = mw_op & ex_mask;
                            default:          ex_res = ((op_c & mw_keep) | mw_op) & ex_mask;
                        endcase
                    end
                end
                default: ex_status = a64dp_pkg::ST_UNDEF_GROUP;
            endcase
        end else if (is_mul) begin
            ex_res = mul_res;
        end else if (!ex_sf && ex_amt[5]) begin
            // 32-bit form with shift amount of 32 or more
            ex_status = a64dp_pkg::ST_RESERVED;
        end else if (r_iw[24]) begin
            if (ex_kind == a64dp_pkg::SHIFT_ROR) begin
                ex_status = a64dp_pkg::ST_RESERVED;
            end else if (ex_rd == a64dp_pkg::ZERO_REG && !ex_opc[0]) begin
                ex_status = a64dp_pkg::ST_SP_UNSUPPORTED;
            end else begin
                ex_res = as_reg.res;
                if (ex_opc[0]) begin
                    ex_flags = as_reg.nzcv;
                end
            end
        end else begin
            ex_res = log_res;
            if (ex_opc == a64dp_pkg::LOG_ANDS) begin
                ex_flags = {top_bit(log_res, ex_sf), (log_res == '0), 2'b00};
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [AW-1:0]   r_o_rd;
    logic            r_o_we;
    logic [XLEN-1:0] r_o_val;
    logic [3:0]      r_o_flags;
    logic [1:0]      r_o_status;
    logic [3:0]      n_flags;

    // drop the update on any error status
    assign n_flags = (ex_status == a64dp_pkg::ST_OK) ? ex_flags : r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_mul_phase <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_flags     <= '0;
        end else begin
            if (in_xfer) begin
                r_ex_valid <= 1'b1;
            end else if (ex_fire) begin
                r_ex_valid <= 1'b0;
            end

            if (ex_fire) begin
                r_mul_phase <= 1'b0;
            end else if (r_ex_valid && is_mul) begin
                r_mul_phase <= 1'b1;
            end

            if (ex_fire) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end

            if (reg_we) begin
                r_valid[ex_rd] <= 1'b1;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_iw      <= i_in.instruction_word;
            r_imm     <= i_in.immediate_group;
            r_hit_a   <= reg_we && (ex_rd == addr_a);
            r_hit_b   <= reg_we && (ex_rd == addr_b);
            r_hit_c   <= reg_we && (ex_rd == addr_c);
            r_ok_a    <= (addr_a != a64dp_pkg::ZERO_REG) && r_valid[addr_a];
            r_ok_b    <= (addr_b != a64dp_pkg::ZERO_REG) && r_valid[addr_b];
            r_ok_c    <= (addr_c != a64dp_pkg::ZERO_REG) && r_valid[addr_c];
            r_fwd_val <= ex_res;
        end
        if (r_ex_valid && is_mul && !r_mul_phase) begin
            r_p0  <= mul_ll;
            r_p1  <= mul_lh;
            r_p2  <= mul_hl;
            r_acc <= op_c;
        end
        if (ex_fire) begin
            r_o_rd     <= ex_rd;
            r_o_we     <= (ex_status == a64dp_pkg::ST_OK) && (ex_rd != a64dp_pkg::ZERO_REG);
            r_o_val    <= (ex_status == a64dp_pkg::ST_OK) ? ex_res : '0;
            r_o_flags  <= n_flags;
            r_o_status <= ex_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.dest_index   = r_o_rd;
    assign o_out.write_enable = r_o_we;
    assign o_out.write_value  = r_o_val;
    assign o_out.flag_n       = r_o_flags[a64dp_pkg::FLAG_N];
    assign o_out.flag_z       = r_o_flags[a64dp_pkg::FLAG_Z];
    assign o_out.flag_c       = r_o_flags[a64dp_pkg::FLAG_C];
    assign o_out.flag_v       = r_o_flags[a64dp_pkg::FLAG_V];
    assign o_out.status       = r_o_status;

`ifndef SYNTH
    // an error result never reports a write
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status != a64dp_pkg::ST_OK) |-> (!r_o_we && r_o_val == '0))
        else $error("error status with write reported");

    // the zero register is never reported as written
    a_no_zr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_we) |-> (r_o_rd != a64dp_pkg::ZERO_REG))
        else $error("write reported to zero register");

    // no transfer-in while the multiply partial products are being formed
    a_mul_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex_valid && is_mul && !r_mul_phase) |-> !i_in.ready)
        else $error("transfer-in during first multiply cycle");

    // a retired write marks its register as valid
    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reg_we |=> r_valid[$past(ex_rd)])
        else $error("register valid bit not set after write");
`endif

endmodule

[dv/a64dp_exec_checker.sv]
`timescale 1ns / 100ps

module a64dp_exec_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    a64dp_in_if   i_in_mon,
    a64dp_out_if  i_out_mon,
    output int    o_fail_count,
    output int    o_pending
);
    import a64dp_pkg::*;

    typedef struct packed {
        logic [4:0]      dest_index;
        logic            write_enable;
        logic [XLEN-1:0] write_value;
        logic [3:0]      nzcv;
        logic [1:0]      status;
    } exec_result_t;

    logic [XLEN-1:0] xreg [REG_COUNT];
    logic [3:0]      nzcv_q;
    exec_result_t    expected_q [$];
    int              fail_count = 0;
    int              pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic [XLEN-1:0] read_x(logic [4:0] idx);
        return (idx == ZERO_REG) ? '0 : xreg[idx];
    endfunction

    function automatic logic [XLEN-1:0] width_mask(logic wide);
        return wide ? {XLEN{1'b1}} : {{HALF_XLEN{1'b0}}, {HALF_XLEN{1'b1}}};
    endfunction

    function automatic logic [XLEN-1:0] shift_operand(logic [XLEN-1:0] v, logic [1:0] kind,
                                                       int unsigned amt, logic wide);
        logic [XLEN-1:0] mask;
        int unsigned     w;
        mask = width_mask(wide);
        w = wide ? XLEN : HALF_XLEN;
        v &= mask;
        case (kind)
            SHIFT_LSL: return (v << amt) & mask;
            SHIFT_LSR: return v >> amt;
            SHIFT_ASR: return v[w-1] ? ((v >> amt) | (mask & ~(mask >> amt))) : (v >> amt);
            default:   return (amt == 0) ? v : (((v >> amt) | (v << (w - amt))) & mask);
        endcase
    endfunction

    // opc bit 1 selects subtract, bit 0 updates NZCV
    function automatic t_addsub add_sub(logic [1:0] opc, logic [XLEN-1:0] a, logic [XLEN-1:0] b,
                                        logic wide, logic [3:0] flags_in);
        logic [XLEN-1:0] mask, sum, ovf;
        int unsigned     w;
        logic            c;
        t_addsub         r;
        mask = width_mask(wide);
        w = wide ? XLEN : HALF_XLEN;
        a &= mask;
        b &= mask;
        if (!opc[1]) begin
            sum = (a + b) & mask;
            c   = sum < a;
            ovf = ~(a ^ b) & (a ^ sum);
        end else begin
            sum = (a - b) & mask;
            c   = a >= b;
            ovf = (a ^ b) & (a ^ sum);
        end
        r.res  = sum;
        r.nzcv = opc[0] ? {sum[w-1], sum == '0, c, ovf[w-1]} : flags_in;
        return r;
    endfunction

    // Execute one instruction against the shadow registers and flags.
    function automatic exec_result_t execute_instr(logic [31:0] iw, logic imm_grp);
        logic [4:0]      rd, rn, rm;
        logic [1:0]      opc, kind;
        logic            wide;
        logic [XLEN-1:0] mask, res, op, a_val, b_val, prod, acc;
        int unsigned     w, amt, sh;
        logic [3:0]      flags;
        logic [1:0]      st;
        t_addsub         ar;
        exec_result_t    r;
        rd    = iw[4:0];
        rn    = iw[9:5];
        rm    = iw[20:16];
        opc   = iw[30:29];
        wide  = iw[31];
        w     = wide ? XLEN : HALF_XLEN;
        mask  = width_mask(wide);
        flags = nzcv_q;
        res   = '0;
        st    = ST_OK;
        if (imm_grp) begin
            if (iw[25:23] == OPI_ADD_SUB) begin
                op = {{(XLEN-12){1'b0}}, iw[21:10]};
                if (iw[22]) op = op << IMM_SHIFT;
                if (rn == ZERO_REG || (rd == ZERO_REG && !opc[0])) begin
                    st = ST_SP_UNSUPPORTED;
                end else begin
                    ar    = add_sub(opc, read_x(rn), op, wide, flags);
                    res   = ar.res;
                    flags = ar.nzcv;
                end
            end else if (iw[25:23] == OPI_MOVE_WIDE) begin
                sh = iw[22:21] * HALF_SHIFT;
                if (opc == MOV_RSVD || (!wide && iw[22])) begin
                    st = ST_RESERVED;
                end else begin
                    op = {{(XLEN-16){1'b0}}, iw[20:5]} << sh;
                    case (opc)
                        MOV_N:   res = ~op & mask;
                        MOV_Z:   res = op & mask;
                        default: res = ((read_x(rd) & ~({{(XLEN-16){1'b0}}, HALF_MASK} << sh))
                                        | op) & mask;
                    endcase
                end
            end else begin
                st = ST_UNDEF_GROUP;
            end
        end else if (iw[28]) begin
            // multiply-add: only sf, rm, x, ra, rn, rd matter
            prod = read_x(rn) * read_x(rm);
            acc  = read_x(iw[14:10]);
            res  = (iw[15] ? acc - prod : acc + prod) & mask;
        end else begin
            amt  = iw[15:10];
            kind = iw[23:22];
            if (amt >= w) begin
                st = ST_RESERVED;
            end else if (iw[24]) begin
                if (kind == SHIFT_ROR) begin
                    st = ST_RESERVED;
                end else if (rd == ZERO_REG && !opc[0]) begin
                    st = ST_SP_UNSUPPORTED;
                end else begin
                    ar    = add_sub(opc, read_x(rn), shift_operand(read_x(rm), kind, amt, wide),
                                    wide, flags);
                    res   = ar.res;
                    flags = ar.nzcv;
                end
            end else begin
                a_val = read_x(rn) & mask;
                b_val = shift_operand(read_x(rm), kind, amt, wide);
                if (iw[21]) b_val = ~b_val & mask;
                case (opc)
                    LOG_ORR: res = a_val | b_val;
                    LOG_EOR: res = a_val ^ b_val;
                    default: res = a_val & b_val;
                endcase
                if (opc == LOG_ANDS) flags = {res[w-1], res == '0, 2'b00};
            end
        end
        r.dest_index = rd;
        if (st == ST_OK) begin
            nzcv_q = flags;
            if (rd != ZERO_REG) xreg[rd] = res;
            r.write_enable = (rd != ZERO_REG);
            r.write_value  = res;
        end else begin
            r.write_enable = 1'b0;
            r.write_value  = '0;
        end
        r.nzcv   = nzcv_q;
        r.status = st;
        return r;
    endfunction

    task automatic check_field(string name, logic [XLEN-1:0] exp_v, logic [XLEN-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        exec_result_t exp_r;
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) xreg[k] = '0;
            nzcv_q = '0;
            expected_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual dest %0d value %h status %0d",
                             $time, i_out_mon.dest_index, i_out_mon.write_value,
                             i_out_mon.status);
                    fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("dest_index", exp_r.dest_index, i_out_mon.dest_index);
                    check_field("write_enable", exp_r.write_enable, i_out_mon.write_enable);
                    check_field("write_value", exp_r.write_value, i_out_mon.write_value);
                    check_field("flag_n", exp_r.nzcv[FLAG_N], i_out_mon.flag_n);
                    check_field("flag_z", exp_r.nzcv[FLAG_Z], i_out_mon.flag_z);
                    check_field("flag_c", exp_r.nzcv[FLAG_C], i_out_mon.flag_c);
                    check_field("flag_v", exp_r.nzcv[FLAG_V], i_out_mon.flag_v);
                    check_field("status", exp_r.status, i_out_mon.status);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                expected_q.push_back(execute_instr(i_in_mon.instruction_word,
                                                   i_in_mon.immediate_group));
        end
        pending = expected_q.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the A64 execute core. The checker instance beside the
// DUT owns prediction and comparison; this module only drives the two channels.
module testbench;
    import a64dp_pkg::*;

    localparam int RANDOM_ITEMS    = 625;
    localparam int CALM_TAIL       = 100;     // last random items run with no idling
    localparam int PRESSURE_CYCLES = 300;     // long receiver hold-off
    localparam int DRAIN_CYCLES    = 10;
    localparam int LIMIT_CYCLES    = 200000;

    // add/sub opc encodings (bit 1 subtract, bit 0 set flags)
    localparam logic [1:0] OPC_ADD  = 2'b00;
    localparam logic [1:0] OPC_ADDS = 2'b01;
    localparam logic [1:0] OPC_SUB  = 2'b10;
    localparam logic [1:0] OPC_SUBS = 2'b11;

    localparam logic GRP_REG = 1'b0;
    localparam logic GRP_IMM = 1'b1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   idle_on;
    bit   hold_req;
    logic in_xfer;

    always #5 i_clk = ~i_clk;

    a64dp_in_if  instr_ch ();
    a64dp_out_if result_ch ();

    a64_data_processing_execute_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    a64dp_exec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (instr_ch),
        .i_out_mon    (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Capture the input transfer at the rising edge; the driver acts on it at the
    // following falling edge, so it never races the DUT's own updates.
    always @(posedge i_clk) in_xfer <= instr_ch.valid & instr_ch.ready;

    // ---------------------------------------------------------------------
    // Encoders for the forms the core executes
    // ---------------------------------------------------------------------
    function automatic logic [31:0] enc_add_imm(logic wide, logic [1:0] opc, logic sh,
                                                logic [11:0] imm12, logic [4:0] rn,
                                                logic [4:0] rd);
        return {wide, opc, 3'b100, OPI_ADD_SUB, sh, imm12, rn, rd};
    endfunction

    function automatic logic [31:0] enc_movw(logic wide, logic [1:0] opc, logic [1:0] hw,
                                             logic [15:0] imm16, logic [4:0] rd);
        return {wide, opc, 3'b100, OPI_MOVE_WIDE, hw, imm16, rd};
    endfunction

    // shifted register form: arith selects add/sub (bit 24), inv is the N bit
    function automatic logic [31:0] enc_shreg(logic wide, logic [1:0] opc, logic arith,
                                              logic [1:0] kind, logic inv, logic [4:0] rm,
                                              logic [5:0] amt, logic [4:0] rn, logic [4:0] rd);
        return {wide, opc, 1'b0, 3'b101, arith, kind, inv, rm, amt, rn, rd};
    endfunction

    function automatic logic [31:0] enc_madd(logic wide, logic sub, logic [4:0] rm,
                                             logic [4:0] ra, logic [4:0] rn, logic [4:0] rd);
        return {wide, 2'b00, 1'b1, 4'b1011, 3'b000, rm, sub, ra, rn, rd};
    endfunction

    // Favor a few low registers so results feed later instructions; keep the
    // zero register in the mix.
    function automatic logic [4:0] pick_reg();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return ZERO_REG;
        if (r < 12) return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 30));
    endfunction

    function automatic logic [15:0] pick_imm16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return HALF_MASK;
            default: return 16'($urandom);
        endcase
    endfunction

    // Returns {group, instruction word}. Most items are well-formed with random
    // content; a slice is reserved encodings and raw noise.
    function automatic logic [32:0] random_instr();
        int          sel;
        logic        wide;
        logic [1:0]  opc;
        logic [5:0]  amt;
        logic [11:0] imm12;
        sel  = $urandom_range(0, 19);
        wide = ($urandom_range(0, 3) != 0);
        opc  = 2'($urandom_range(0, 3));
        amt  = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 31));
        if (sel <= 3) begin
            imm12 = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom);
            return {GRP_IMM, enc_add_imm(wide, opc, 1'($urandom), imm12, pick_reg(),
                                         pick_reg())};
        end else if (sel <= 7) begin
            case ($urandom_range(0, 3))
                0:       opc = MOV_N;
                1:       opc = MOV_Z;
                default: opc = MOV_K;
            endcase
            return {GRP_IMM, enc_movw(wide, opc, wide ? 2'($urandom_range(0, 3))
                                                      : 2'($urandom_range(0, 1)),
                                      pick_imm16(), pick_reg())};
        end else if (sel <= 10) begin
            return {GRP_REG, enc_shreg(wide, opc, 1'b1, 2'($urandom_range(0, 2)),
                                       1'($urandom), pick_reg(), amt, pick_reg(), pick_reg())};
        end else if (sel <= 13) begin
            return {GRP_REG, enc_shreg(wide, opc, 1'b0, 2'($urandom), 1'($urandom),
                                       pick_reg(), amt, pick_reg(), pick_reg())};
        end else if (sel <= 15) begin
            return {GRP_REG, enc_madd(wide, 1'($urandom), pick_reg(), pick_reg(), pick_reg(),
                                      pick_reg())};
        end else if (sel == 16) begin
            // broken: 32-bit shift amount out of range, or reserved wide move
            if ($urandom_range(0, 1))
                return {GRP_REG, enc_shreg(1'b0, opc, 1'($urandom), 2'($urandom),
                                           1'($urandom), pick_reg(),
                                           6'($urandom_range(32, 63)), pick_reg(), pick_reg())};
            return {GRP_IMM, enc_movw(wide, MOV_RSVD, 2'($urandom), pick_imm16(), pick_reg())};
        end
        return {1'($urandom), 32'($urandom)};
    endfunction

    // Offer one instruction and hold it until transferred. Called at a falling
    // edge and returns at one. valid drops only when an idle burst is taken.
    task automatic send_instr(logic [31:0] iw, logic grp);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            instr_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        instr_ch.valid            <= 1'b1;
        instr_ch.instruction_word <= iw;
        instr_ch.immediate_group  <= grp;
        do @(negedge i_clk); while (!in_xfer);
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (hold_req) begin
                // hold off long enough for the core to back up and stall its input
                hold_req   = 1'b0;
                stall_left = PRESSURE_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 11);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        logic [32:0] item;
        instr_ch.valid            = 1'b0;
        instr_ch.instruction_word = '0;
        instr_ch.immediate_group  = GRP_REG;
        idle_on  = 1'b0;
        hold_req = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: build known values, then hit each special case.
        send_instr(enc_movw(1'b1, MOV_Z, 2'd3, HALF_MASK, 5'd1), GRP_IMM);     // top halfword
        send_instr(enc_movw(1'b1, MOV_N, 2'd0, 16'h0000, 5'd2), GRP_IMM);      // all ones
        send_instr(enc_movw(1'b1, MOV_K, 2'd1, 16'h1234, 5'd2), GRP_IMM);      // keep the rest
        send_instr(enc_movw(1'b0, MOV_N, 2'd0, 16'h0000, 5'd3), GRP_IMM);      // zero-extended
        send_instr(enc_movw(1'b0, MOV_Z, 2'd2, 16'hABCD, 5'd4), GRP_IMM);      // 32-bit hw 2
        send_instr(enc_movw(1'b1, MOV_RSVD, 2'd0, 16'h5555, 5'd4), GRP_IMM);   // reserved opc
        send_instr(32'h0000_0000, GRP_IMM);                                    // undefined group
        send_instr(enc_movw(1'b0, MOV_Z, 2'd0, HALF_MASK, 5'd7), GRP_IMM);
        send_instr(enc_movw(1'b0, MOV_K, 2'd1, 16'h7FFF, 5'd7), GRP_IMM);      // w7 = max positive
        send_instr(enc_add_imm(1'b0, OPC_ADDS, 1'b0, 12'h001, 5'd7, 5'd8), GRP_IMM);  // overflow
        send_instr(enc_add_imm(1'b1, OPC_ADDS, 1'b1, 12'hFFF, 5'd2, 5'd9), GRP_IMM);  // shifted imm, no carry
        send_instr(enc_add_imm(1'b1, OPC_ADD, 1'b0, 12'h001, ZERO_REG, 5'd5), GRP_IMM);
        send_instr(enc_add_imm(1'b1, OPC_SUB, 1'b0, 12'h001, 5'd1, ZERO_REG), GRP_IMM);
        send_instr(enc_add_imm(1'b1, OPC_SUBS, 1'b0, 12'hFFF, 5'd1, ZERO_REG), GRP_IMM);
        send_instr(enc_shreg(1'b1, OPC_SUBS, 1'b1, SHIFT_LSL, 1'b0, 5'd1, 6'd0, 5'd1, 5'd6),
                   GRP_REG);                                                   // equal operands
        send_instr(enc_shreg(1'b1, OPC_ADD, 1'b1, SHIFT_ROR, 1'b0, 5'd1, 6'd4, 5'd2, 5'd10),
                   GRP_REG);                                                   // no rotate in arith
        send_instr(enc_shreg(1'b0, OPC_ADD, 1'b1, SHIFT_LSL, 1'b0, 5'd1, 6'd32, 5'd2, 5'd10),
                   GRP_REG);                                                   // amount too large
        send_instr(enc_shreg(1'b1, OPC_ADD, 1'b1, SHIFT_LSL, 1'b0, 5'd1, 6'd1, 5'd2, ZERO_REG),
                   GRP_REG);
        send_instr(enc_shreg(1'b1, OPC_ADDS, 1'b1, SHIFT_LSL, 1'b1, 5'd2, 6'd63, 5'd1, 5'd11),
                   GRP_REG);                                                   // N bit ignored
        send_instr(enc_shreg(1'b1, LOG_ANDS, 1'b0, SHIFT_ROR, 1'b1, 5'd2, 6'd0, 5'd1, 5'd12),
                   GRP_REG);                                                   // rotate by zero
        send_instr(enc_shreg(1'b1, LOG_ORR, 1'b0, SHIFT_ASR, 1'b0, 5'd1, 6'd63, ZERO_REG, 5'd13),
                   GRP_REG);
        send_instr(enc_shreg(1'b0, LOG_EOR, 1'b0, SHIFT_LSR, 1'b0, 5'd3, 6'd31, 5'd2, 5'd14),
                   GRP_REG);
        send_instr(enc_shreg(1'b0, LOG_ORR, 1'b0, SHIFT_ROR, 1'b0, 5'd7, 6'd5, ZERO_REG, 5'd18),
                   GRP_REG);
        send_instr(enc_shreg(1'b1, LOG_AND, 1'b0, SHIFT_LSL, 1'b0, ZERO_REG, 6'd0, 5'd2, 5'd15),
                   GRP_REG);
        send_instr(enc_madd(1'b1, 1'b0, 5'd2, 5'd3, 5'd1, 5'd16), GRP_REG);
        send_instr(enc_madd(1'b0, 1'b1, 5'd3, ZERO_REG, 5'd2, 5'd17), GRP_REG);
        send_instr(enc_shreg(1'b1, LOG_ANDS, 1'b0, SHIFT_ROR, 1'b0, 5'd1, 6'd1, 5'd1, ZERO_REG),
                   GRP_REG);                                                   // flags only

        // Random: start with the long receiver hold-off, then alternate idling
        // stretches with calm ones, and finish with no idling at all.
        hold_req = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 80) % 3 != 2);
            item = random_instr();
            send_instr(item[31:0], item[32]);
        end
        instr_ch.valid <= 1'b0;

        // Drain, then give the multiply path a few more edges to misbehave.
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
